// ===== src/leb128_stream_decoder_top_assert.svh =====
// Assertion macros used by the decoder top module.
`ifndef LEB128_STREAM_DECODER_TOP_ASSERT_SVH
`define LEB128_STREAM_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LEB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LEB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/leb_pkg.sv =====
`default_nettype none
package leb_pkg;

  // Default width of a decoded value
  localparam int DefaultValueBits = 64;

  localparam logic [6:0] PayloadMask = 7'h7f;
  localparam int         ContBit     = 7;
  localparam int         SignBit     = 6;

  // Result status codes
  typedef enum logic [1:0] {
    ST_COMPLETE = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_TRUNC    = 2'd2
  } status_t;

  // One input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       signed_mode;
    logic       buffer_end;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [63:0] value;
    status_t     status;
    logic [3:0]  used;
  } res_beat_t;

endpackage
`default_nettype wire

// ===== src/leb_in_stage.sv =====
`default_nettype none
module leb_in_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire leb_pkg::in_beat_t beat_in,
  input  wire logic              advance,
  output logic                   beat_valid,
  output leb_pkg::in_beat_t      beat
);

  // Hold the beat until the decode stage takes it
  assign in_stall = beat_valid && !advance;

  // Track occupancy of the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (!in_stall) begin
      beat_valid <= in_valid;
    end
  end

  // Load the payload whenever the register frees up
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      beat <= beat_in;
    end
  end

endmodule
`default_nettype wire

// ===== src/leb_step.sv =====
`default_nettype none
module leb_step #(
  parameter int VALUE_BITS = leb_pkg::DefaultValueBits
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire leb_pkg::in_beat_t beat,
  output logic                   has_result,
  output leb_pkg::res_beat_t     res
);

  localparam logic [7:0] VbW = 8'(VALUE_BITS);

  logic [63:0] accumulator;
  logic [63:0] accumulator_next;
  logic [3:0]  byte_count;
  logic [3:0]  byte_count_next;
  logic        value_signed;

  logic        sgn;
  logic [63:0] base;
  logic [7:0]  shift;
  logic [7:0]  shift_end;
  logic [7:0]  k;
  logic [6:0]  payload;
  logic        more;
  logic [3:0]  used;
  logic [6:0]  hi;
  logic [6:0]  all_ones;
  logic        ovf;
  logic [63:0] acc_or;
  logic [63:0] ext;

  // Decode one byte against the running state
  always_comb begin
    sgn       = (byte_count == 4'd0) ? beat.signed_mode : value_signed;
    base      = (byte_count == 4'd0) ? 64'd0 : accumulator;
    shift     = {1'b0, {byte_count, 3'b000} - {3'b000, byte_count}};
    shift_end = shift + 8'd7;
    k         = VbW - shift;
    payload   = beat.data_byte[6:0] & leb_pkg::PayloadMask;
    more      = beat.data_byte[leb_pkg::ContBit];
    used      = byte_count + 4'd1;
    hi        = payload >> (k - 8'd1);
    all_ones  = leb_pkg::PayloadMask >> (k - 8'd1);
    ovf       = 1'b0;

    // Check the final byte position for excess payload
    if (shift >= VbW) begin
      ovf = 1'b1;
    end else if (shift_end >= VbW) begin
      if (more) begin
        ovf = 1'b1;
      end else if (shift_end > VbW) begin
        if (sgn) begin
          ovf = (hi != 7'd0) && (hi != all_ones);
        end else begin
          ovf = (payload >> k) != 7'd0;
        end
      end
    end

    acc_or = base | ({57'd0, payload} << shift);
    ext    = (sgn && beat.data_byte[leb_pkg::SignBit] && (shift_end < 8'd64))
             ? (~64'd0 << shift_end) : 64'd0;

    has_result = ovf || !more || beat.buffer_end;
    res.used   = used;
    if (ovf) begin
      res.value  = 64'd0;
      res.status = leb_pkg::ST_OVERFLOW;
    end else if (!more) begin
      res.value  = acc_or | ext;
      res.status = leb_pkg::ST_COMPLETE;
    end else begin
      res.value  = acc_or;
      res.status = leb_pkg::ST_TRUNC;
    end

    // Restart after any result, else advance the partial value
    if (has_result) begin
      accumulator_next = 64'd0;
      byte_count_next  = 4'd0;
    end else begin
      accumulator_next = acc_or;
      byte_count_next  = used;
    end
  end

  // Update decoder state on each taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= 64'd0;
      byte_count   <= 4'd0;
      value_signed <= 1'b0;
    end else if (take) begin
      accumulator  <= accumulator_next;
      byte_count   <= byte_count_next;
      value_signed <= sgn;
    end
  end

endmodule
`default_nettype wire

// ===== src/leb128_stream_decoder_top.sv =====
// LEB128 stream decoder: takes one encoded byte per cycle while neither side
// stalls and returns one decoded value for each byte that ends a value,
// overflows the VALUE_BITS limit, or is the last byte of the buffer in
// mid-value. A byte passes through an input register and then a result
// register, and out_valid rises once its result is loaded there; the running
// accumulator is updated by a combinational shift-and-OR on each taken byte.
// Both sides may stall freely. status reads 0 complete, 1 overflow (value
// zero), 2 truncated (raw partial bits, no sign extension).
`default_nettype none
`include "leb128_stream_decoder_top_assert.svh"
module leb128_stream_decoder_top #(
  parameter int VALUE_BITS = leb_pkg::DefaultValueBits
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        signed_mode,
  input  wire logic        buffer_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      decoded_value,
  output logic [1:0]       status,
  output logic [3:0]       bytes_used
);

  localparam logic [3:0] MaxBytes = 4'((VALUE_BITS + 6) / 7);

  leb_pkg::in_beat_t  beat_in;
  leb_pkg::in_beat_t  beat;
  leb_pkg::res_beat_t res;
  logic               beat_valid;
  logic               has_result;
  logic               out_free;
  logic               advance;
  logic               res_load;

  assign beat_in = '{data_byte: data_byte, signed_mode: signed_mode,
                     buffer_end: buffer_end};

  // Move a beat through decode when its result has somewhere to go
  assign out_free = !out_valid || !out_stall;
  assign advance  = beat_valid && (!has_result || out_free);
  assign res_load = advance && has_result;

  leb_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .beat_in    (beat_in),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  leb_step #(
    .VALUE_BITS (VALUE_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .take       (advance),
    .beat       (beat),
    .has_result (has_result),
    .res        (res)
  );

  // Hold the result beat until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      decoded_value <= res.value;
      status        <= res.status;
      bytes_used    <= res.used;
    end
  end

  `LEB_ASSERT_NOW(a_ovf_zero, clk, rst,
    out_valid && (status == leb_pkg::ST_OVERFLOW), decoded_value == 64'd0,
    "overflow result carries nonzero value")
  `LEB_ASSERT_NOW(a_used_range, clk, rst,
    out_valid, (bytes_used != 4'd0) && (bytes_used <= MaxBytes),
    "bytes_used out of range")
  `LEB_ASSERT_NOW(a_trunc_short, clk, rst,
    out_valid && (status == leb_pkg::ST_TRUNC), bytes_used < MaxBytes,
    "truncated result at final byte position")
  `LEB_ASSERT_NEXT(a_drain, clk, rst,
    out_valid && !out_stall && !res_load, !out_valid,
    "result beat repeated after delivery")

endmodule
`default_nettype wire
